// ----- rtl/ihnc_pkg.sv -----
package ihnc_pkg;

  localparam int HOST_SLOTS_DEF = 1024;
  localparam int NET_SLOTS_DEF  = 1024;
  localparam int COUNT_BITS_DEF = 20;

  // request codes
  localparam logic [1:0] REQ_RECORD    = 2'd0;
  localparam logic [1:0] REQ_READ_HOST = 2'd1;
  localparam logic [1:0] REQ_READ_NET  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_HOST_FULL  = 2'd1;
  localparam logic [1:0] ST_NET_FULL   = 2'd2;

  // byte fold by 131: weights 131^3, 131^2, 131
  localparam logic [31:0] HASH_W1 = 32'd131;
  localparam logic [31:0] HASH_W2 = 32'd17161;
  localparam logic [31:0] HASH_W3 = 32'd2248091;

  localparam logic [10:0] NET_COUNT_MAX = 11'h7FF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [9:0]  slot;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_new_host;
    logic        slot_used;
    logic [31:0] key;
    logic [19:0] count;
    logic [10:0] net_host_count;
    logic [19:0] max_host_entries;
    logic [10:0] max_network_hosts;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [10:0] count;
  } net_entry_t;

endpackage

// ----- rtl/ihnc_mod.sv -----
// Remainder of a 32-bit hash by the table depth.
module ihnc_mod #(
  parameter int M = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          value,
  output logic                 valid,
  output logic [$clog2(M)-1:0] rem
);
  import ihnc_pkg::*;

  localparam int  IW   = $clog2(M);
  localparam bit  POW2 = ((M & (M - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          valid <= 1'b0;
        end else if (start) begin
          valid <= 1'b1;
        end
        if (start) begin
          rem <= value[IW-1:0];
        end
      end
    end else begin : g_recip
      // quotient by reciprocal multiply, exact for every 32-bit value;
      // value registered, then product, then remainder, and valid rises with the remainder
      localparam logic [63:0] RECIP =
        ((64'd1 << (32 + IW)) + 64'(M) - 64'd1) / 64'(M);

      logic [31:0] val_q;
      logic [64:0] prod;
      logic [1:0]  stg;
      logic [31:0] quo;
      logic [31:0] diff;

      assign quo  = 32'(prod >> (32 + IW));
      assign diff = val_q - quo * 32'(M);

      always_ff @(posedge clk) begin
        if (rst) begin
          valid <= 1'b0;
          stg   <= '0;
        end else begin
          stg <= {stg[0], start};
          if (start) begin
            valid <= 1'b0;
          end else if (stg[1]) begin
            valid <= 1'b1;
          end
        end
        if (start) begin
          val_q <= value;
        end
        if (stg[0]) begin
          prod <= 65'(val_q) * 65'(RECIP[32:0]);
        end
        if (stg[1]) begin
          rem <= IW'(diff);
        end
      end
    end
  endgenerate

endmodule

// ----- rtl/ihnc_table.sv -----
// Single-port-write, single-port-read table with registered read data.
module ihnc_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);
  import ihnc_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/ip_host_network_counter.sv -----
// Channel   Handshake            Payload
// request   start in, busy out   req (req_type, address, slot)
// result    done out, 1 cycle    rsp (status ... max_network_hosts)
//
// After reset a clearing pass writes every slot of both tables, with busy high. A
// slot read registers the table entry in S_IDLE and answers from S_READ; an undefined
// request code is answered from the idle state and never raises busy. A record runs
// hash reduction, then the host probe walk, then the network probe walk and a commit;
// a full host table ends it after the host walk. One request is in flight at a time;
// done is a single cycle beat.
module ip_host_network_counter #(
  parameter int HOST_SLOTS = ihnc_pkg::HOST_SLOTS_DEF,
  parameter int NET_SLOTS  = ihnc_pkg::NET_SLOTS_DEF,
  parameter int COUNT_BITS = ihnc_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ihnc_pkg::req_t req,
  output logic          done,
  output ihnc_pkg::rsp_t rsp
);
  import ihnc_pkg::*;

  localparam int HIW  = $clog2(HOST_SLOTS);
  localparam int NIW  = $clog2(NET_SLOTS);
  localparam int CB   = COUNT_BITS;
  localparam int HEW  = 1 + 32 + CB;
  localparam int NEW  = $bits(net_entry_t);
  localparam int MAXD = (HOST_SLOTS > NET_SLOTS) ? HOST_SLOTS : NET_SLOTS;
  localparam int CLW  = $clog2(MAXD);
  localparam logic [CB-1:0] HOST_COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HPROBE, S_NSTART, S_NPROBE, S_COMMIT, S_READ
  } state_t;

  typedef enum logic [1:0] {PR_FREE, PR_FOUND, PR_FULL} probe_t;

  state_t         state;
  req_t           cur;
  logic [HIW-1:0] hidx, hsteps, h_nxt;
  logic [NIW-1:0] nidx, nsteps, n_nxt;
  probe_t         hres, nres;
  logic [CB-1:0]  hcnt, best_h, hnew;
  logic [10:0]    ncnt, best_n, nnew, netc;
  logic [CLW-1:0] clr_cnt;

  // hash
  logic [31:0] h_hash, n_hash;
  logic        mod_start, hmod_valid, nmod_valid;
  logic [HIW-1:0] hmod_rem;
  logic [NIW-1:0] nmod_rem;

  // tables
  logic           h_rd_en, h_wr_en, n_rd_en, n_wr_en;
  logic [HIW-1:0] h_rd_addr, h_wr_addr;
  logic [NIW-1:0] n_rd_addr, n_wr_addr;
  logic [HEW-1:0] h_rd_data, h_wr_data;
  net_entry_t     n_rd_data, n_wr_data;

  logic           hv;
  logic [31:0]    hk;
  logic [CB-1:0]  hc;
  logic           h_in_range, n_in_range;

  assign h_hash = 32'(req.address[31:24]) * HASH_W3 + 32'(req.address[23:16]) * HASH_W2
                + 32'(req.address[15:8]) * HASH_W1 + 32'(req.address[7:0]);
  assign n_hash = 32'(req.address[31:24]) * HASH_W1 + 32'(req.address[23:16]);
  assign mod_start = (state == S_IDLE) && start && (req.req_type == REQ_RECORD);

  ihnc_mod #(.M(HOST_SLOTS)) u_hmod (
    .clk(clk), .rst(rst), .start(mod_start), .value(h_hash),
    .valid(hmod_valid), .rem(hmod_rem)
  );

  ihnc_mod #(.M(NET_SLOTS)) u_nmod (
    .clk(clk), .rst(rst), .start(mod_start), .value(n_hash),
    .valid(nmod_valid), .rem(nmod_rem)
  );

  ihnc_table #(.DEPTH(HOST_SLOTS), .WIDTH(HEW)) u_host (
    .clk(clk), .rd_en(h_rd_en), .rd_addr(h_rd_addr), .rd_data(h_rd_data),
    .wr_en(h_wr_en), .wr_addr(h_wr_addr), .wr_data(h_wr_data)
  );

  ihnc_table #(.DEPTH(NET_SLOTS), .WIDTH(NEW)) u_net (
    .clk(clk), .rd_en(n_rd_en), .rd_addr(n_rd_addr), .rd_data(n_rd_data),
    .wr_en(n_wr_en), .wr_addr(n_wr_addr), .wr_data(n_wr_data)
  );

  assign busy = (state != S_IDLE);

  assign hv = h_rd_data[HEW-1];
  assign hk = h_rd_data[CB+31:CB];
  assign hc = h_rd_data[CB-1:0];

  assign h_nxt = (hidx == HIW'(HOST_SLOTS - 1)) ? '0 : hidx + 1'b1;
  assign n_nxt = (nidx == NIW'(NET_SLOTS - 1)) ? '0 : nidx + 1'b1;

  assign h_in_range = 32'(cur.slot) < 32'(HOST_SLOTS);
  assign n_in_range = 32'(cur.slot) < 32'(NET_SLOTS);

  assign hnew = (hres == PR_FOUND) ? ((hcnt == HOST_COUNT_MAX) ? hcnt : hcnt + 1'b1)
                                   : CB'(1);
  assign nnew = (nres == PR_FOUND) ? ((ncnt == NET_COUNT_MAX) ? ncnt : ncnt + 11'd1)
                                   : 11'd1;
  assign netc = (hres == PR_FOUND) ? ((nres == PR_FOUND) ? ncnt : 11'd0) : nnew;

  always_comb begin
    h_rd_en   = 1'b0;
    h_rd_addr = hidx;
    h_wr_en   = 1'b0;
    h_wr_addr = hidx;
    h_wr_data = {1'b1, cur.address, hnew};
    n_rd_en   = 1'b0;
    n_rd_addr = nidx;
    n_wr_en   = 1'b0;
    n_wr_addr = nidx;
    n_wr_data = '{valid: 1'b1, key: cur.address[31:16], count: nnew};
    unique case (state)
      S_CLEAR: begin
        h_wr_en   = 32'(clr_cnt) < 32'(HOST_SLOTS);
        h_wr_addr = HIW'(clr_cnt);
        h_wr_data = '0;
        n_wr_en   = 32'(clr_cnt) < 32'(NET_SLOTS);
        n_wr_addr = NIW'(clr_cnt);
        n_wr_data = '0;
      end
      S_IDLE: begin
        h_rd_addr = HIW'(req.slot);
        n_rd_addr = NIW'(req.slot);
        h_rd_en   = start && (req.req_type == REQ_READ_HOST);
        n_rd_en   = start && (req.req_type == REQ_READ_NET);
      end
      S_HASH: begin
        h_rd_en   = hmod_valid && nmod_valid;
        h_rd_addr = hmod_rem;
      end
      S_HPROBE: begin
        h_rd_en   = hv && (hk != cur.address);
        h_rd_addr = h_nxt;
      end
      S_NSTART: begin
        n_rd_en   = 1'b1;
        n_rd_addr = nmod_rem;
      end
      S_NPROBE: begin
        n_rd_en   = n_rd_data.valid && (n_rd_data.key != cur.address[31:16]);
        n_rd_addr = n_nxt;
      end
      S_COMMIT: begin
        h_wr_en = (hres == PR_FOUND) || (nres != PR_FULL);
        n_wr_en = (hres == PR_FREE) && (nres != PR_FULL);
      end
      S_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
      best_h  <= '0;
      best_n  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLW'(MAXD - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur <= req;
            unique case (req.req_type)
              REQ_RECORD:                  state <= S_HASH;
              REQ_READ_HOST, REQ_READ_NET: state <= S_READ;
              default: begin
                done <= 1'b1;
                rsp  <= '0;
                rsp.max_host_entries  <= 20'(best_h);
                rsp.max_network_hosts <= best_n;
              end
            endcase
          end
        end
        S_HASH: begin
          if (hmod_valid && nmod_valid) begin
            hidx   <= hmod_rem;
            hsteps <= '0;
            state  <= S_HPROBE;
          end
        end
        S_HPROBE: begin
          if (!hv) begin
            hres  <= PR_FREE;
            state <= S_NSTART;
          end else if (hk == cur.address) begin
            hres  <= PR_FOUND;
            hcnt  <= hc;
            state <= S_NSTART;
          end else if (hsteps == HIW'(HOST_SLOTS - 1)) begin
            // host table full: nothing committed
            state <= S_IDLE;
            done  <= 1'b1;
            rsp   <= '0;
            rsp.status            <= ST_HOST_FULL;
            rsp.key               <= cur.address;
            rsp.max_host_entries  <= 20'(best_h);
            rsp.max_network_hosts <= best_n;
          end else begin
            hsteps <= hsteps + 1'b1;
            hidx   <= h_nxt;
          end
        end
        S_NSTART: begin
          nidx   <= nmod_rem;
          nsteps <= '0;
          state  <= S_NPROBE;
        end
        S_NPROBE: begin
          if (!n_rd_data.valid) begin
            nres  <= PR_FREE;
            state <= S_COMMIT;
          end else if (n_rd_data.key == cur.address[31:16]) begin
            nres  <= PR_FOUND;
            ncnt  <= n_rd_data.count;
            state <= S_COMMIT;
          end else if (nsteps == NIW'(NET_SLOTS - 1)) begin
            nres  <= PR_FULL;
            state <= S_COMMIT;
          end else begin
            nsteps <= nsteps + 1'b1;
            nidx   <= n_nxt;
          end
        end
        S_COMMIT: begin
          state <= S_IDLE;
          done  <= 1'b1;
          rsp   <= '0;
          rsp.key <= cur.address;
          if (hres == PR_FREE && nres == PR_FULL) begin
            rsp.status            <= ST_NET_FULL;
            rsp.max_host_entries  <= 20'(best_h);
            rsp.max_network_hosts <= best_n;
          end else begin
            rsp.status         <= ST_OK;
            rsp.is_new_host    <= (hres == PR_FREE);
            rsp.count          <= 20'(hnew);
            rsp.net_host_count <= netc;
            if (hnew > best_h) begin
              best_h <= hnew;
              rsp.max_host_entries <= 20'(hnew);
            end else begin
              rsp.max_host_entries <= 20'(best_h);
            end
            if (netc > best_n) begin
              best_n <= netc;
              rsp.max_network_hosts <= netc;
            end else begin
              rsp.max_network_hosts <= best_n;
            end
          end
        end
        S_READ: begin
          state <= S_IDLE;
          done  <= 1'b1;
          rsp   <= '0;
          rsp.max_host_entries  <= 20'(best_h);
          rsp.max_network_hosts <= best_n;
          if (cur.req_type == REQ_READ_HOST) begin
            if (h_in_range && hv) begin
              rsp.slot_used <= 1'b1;
              rsp.key       <= hk;
              rsp.count     <= 20'(hc);
            end
          end else if (n_in_range && n_rd_data.valid) begin
            rsp.slot_used <= 1'b1;
            rsp.key       <= {16'd0, n_rd_data.key};
            rsp.count     <= 20'(n_rd_data.count);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result beat only ends a request that was in flight or just accepted
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result beat without a request in flight");

  // running maxima never drop
  a_max_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (best_h >= $past(best_h)) && (best_n >= $past(best_n)))
    else $error("running maximum decreased");

  // a full-table result carries no insert and no counts
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status != ST_OK) |->
      !rsp.is_new_host && (rsp.count == 20'd0) && (rsp.net_host_count == 11'd0))
    else $error("full-table result carries count data");

  // no table write while a request waits in the idle state
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !h_wr_en && !n_wr_en)
    else $error("table write while idle");

endmodule
